// ===== hw/rtl/obr_pkg.sv =====
// ----------------------------------------------------------------------------
// obr_pkg
// shared widths, constants and transaction types of the ohlc bar resampler
// ----------------------------------------------------------------------------
`default_nettype none

package obr_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned PriceW  = 32;
    localparam int unsigned PeriodW = 20;

    localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(60);
    localparam logic [PeriodW-1:0] PeriodOne   = PeriodW'(1);

    // one classified input bar, front to back
    typedef struct packed {
        logic [TimeW-1:0]  interval;
        logic [TimeW-1:0]  start;
        logic [PriceW-1:0] open;
        logic [PriceW-1:0] high;
        logic [PriceW-1:0] low;
        logic [PriceW-1:0] close;
        logic              eos;
    } item_t;

    // one emitted bar
    typedef struct packed {
        logic [TimeW-1:0]  start;
        logic [PriceW-1:0] open;
        logic [PriceW-1:0] high;
        logic [PriceW-1:0] low;
        logic [PriceW-1:0] close;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/obr_divider.sv =====
// ----------------------------------------------------------------------------
// obr_divider
// restoring divider, one quotient bit per cycle, time by period
// ----------------------------------------------------------------------------
`default_nettype none

module obr_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [obr_pkg::TimeW-1:0]    dividend,
    input  wire logic [obr_pkg::PeriodW-1:0]  divisor,
    output logic                              done,
    output logic [obr_pkg::TimeW-1:0]         quotient,
    output logic [obr_pkg::PeriodW-1:0]       remainder
);
    import obr_pkg::*;

    localparam int unsigned CntW = $clog2(TimeW);
    localparam logic [CntW-1:0] LastStep = CntW'(TimeW - 1);

    logic [PeriodW-1:0] rem_reg, rem_next;
    logic [TimeW-1:0]   quo_reg, quo_next;
    logic [PeriodW-1:0] div_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [PeriodW:0] trial;
    logic [PeriodW:0] diff;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[TimeW-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
        quo_next = {quo_reg[TimeW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LastStep) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/obr_front.sv =====
// ----------------------------------------------------------------------------
// obr_front
// accepts input bars and finds their interval index and start time
// ----------------------------------------------------------------------------
`default_nettype none

module obr_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [obr_pkg::PeriodW-1:0]  period,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [obr_pkg::TimeW-1:0]    in_time,
    input  wire logic [obr_pkg::PriceW-1:0]   in_open,
    input  wire logic [obr_pkg::PriceW-1:0]   in_high,
    input  wire logic [obr_pkg::PriceW-1:0]   in_low,
    input  wire logic [obr_pkg::PriceW-1:0]   in_close,
    input  wire logic                         in_eos,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output obr_pkg::item_t                    push_item
);
    import obr_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t state_reg;

    logic [TimeW-1:0]   time_reg;
    logic [PriceW-1:0]  open_reg, high_reg, low_reg, close_reg;
    logic               eos_reg;
    logic               accept;
    logic [PeriodW-1:0] divisor;
    logic               div_done;
    logic [TimeW-1:0]   div_quo;
    logic [PeriodW-1:0] div_rem;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    // a zero period acts as one
    assign divisor  = (period == '0) ? PeriodOne : period;

    obr_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (in_time),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) state_reg <= F_DIV;
                end
                F_DIV: begin
                    if (div_done) state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (push_ready) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg  <= in_time;
            open_reg  <= in_open;
            high_reg  <= in_high;
            low_reg   <= in_low;
            close_reg <= in_close;
            eos_reg   <= in_eos;
        end
    end

    assign push_valid = (state_reg == F_PUSH);

    // interval * period equals time minus remainder
    always_comb begin
        push_item.interval = div_quo;
        push_item.start    = time_reg - {{(TimeW-PeriodW){1'b0}}, div_rem};
        push_item.open     = open_reg;
        push_item.high     = high_reg;
        push_item.low      = low_reg;
        push_item.close    = close_reg;
        push_item.eos      = eos_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/obr_queue.sv =====
// ----------------------------------------------------------------------------
// obr_queue
// short fifo of classified bars between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module obr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire obr_pkg::item_t wr_item,
    output logic                rd_valid,
    input  wire logic           rd_pop,
    output obr_pkg::item_t      rd_item
);
    import obr_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    item_t           mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_wr, do_rd;

    assign wr_ready = (cnt_reg != Full);
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/obr_back.sv =====
// ----------------------------------------------------------------------------
// obr_back
// merges classified bars into the open bar and emits finished bars
// ----------------------------------------------------------------------------
`default_nettype none

module obr_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire obr_pkg::item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output obr_pkg::result_t    out_data
);
    import obr_pkg::*;

    typedef enum logic {
        P_MERGE,
        P_FLUSH
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              bar_valid_reg, bar_valid_next;
    logic [TimeW-1:0]  interval_reg, interval_next;
    logic [TimeW-1:0]  start_reg, start_next;
    logic [PriceW-1:0] open_reg, open_next;
    logic [PriceW-1:0] high_reg, high_next;
    logic [PriceW-1:0] low_reg, low_next;
    logic [PriceW-1:0] close_reg, close_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic same, need_emit, out_free, load;

    always_comb begin
        same      = bar_valid_reg && (q_item.interval == interval_reg);
        need_emit = bar_valid_reg && !same;
        out_free  = !out_valid_reg || out_ready;

        phase_next     = phase_reg;
        bar_valid_next = bar_valid_reg;
        interval_next  = interval_reg;
        start_next     = start_reg;
        open_next      = open_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        close_next     = close_reg;
        out_next       = out_reg;
        load           = 1'b0;
        q_pop          = 1'b0;

        if (q_valid) begin
            unique case (phase_reg)
                P_MERGE: begin
                    if (!need_emit || out_free) begin
                        if (need_emit) begin
                            load     = 1'b1;
                            out_next = '{start: start_reg, open: open_reg, high: high_reg,
                                         low: low_reg, close: close_reg, last: !q_item.eos};
                        end
                        if (same) begin
                            if (q_item.high > high_reg) high_next = q_item.high;
                            if (q_item.low < low_reg)   low_next  = q_item.low;
                            close_next = q_item.close;
                        end else begin
                            bar_valid_next = 1'b1;
                            interval_next  = q_item.interval;
                            start_next     = q_item.start;
                            open_next      = q_item.open;
                            high_next      = q_item.high;
                            low_next       = q_item.low;
                            close_next     = q_item.close;
                        end
                        if (q_item.eos) phase_next = P_FLUSH;
                        else            q_pop      = 1'b1;
                    end
                end
                P_FLUSH: begin
                    if (out_free) begin
                        load           = 1'b1;
                        out_next       = '{start: start_reg, open: open_reg, high: high_reg,
                                           low: low_reg, close: close_reg, last: 1'b1};
                        bar_valid_next = 1'b0;
                        phase_next     = P_MERGE;
                        q_pop          = 1'b1;
                    end
                end
                default: phase_next = P_MERGE;
            endcase
        end

        if (load)           out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= P_MERGE;
            bar_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bar_valid_reg <= bar_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        interval_reg <= interval_next;
        start_reg    <= start_next;
        open_reg     <= open_next;
        high_reg     <= high_next;
        low_reg      <= low_next;
        close_reg    <= close_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ohlc_bar_resampler.sv =====
// path: the 32-step divider, the queue, then the merge that registers the first result,
// or the flush phase after it when the only result is the end-of-series flush
// a new input is accepted only after the last is divided, one bit per cycle, and queued
// an end_of_series input yields up to two results, back to back while m_ready is high
// reset: synchronous active-low aresetn closes any open bar, empties the queue,
// drops pending results and sets the period to 60 seconds
// ----------------------------------------------------------------------------
// ohlc_bar_resampler
// merges time-ordered price bars into bars of a longer configured period
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_bar_resampler #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    // period register write
    input  wire logic                         cfg_wr_en,
    input  wire logic [obr_pkg::PeriodW-1:0]  cfg_wr_data,

    // input bars
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [obr_pkg::TimeW-1:0]    s_tick_time,
    input  wire logic [obr_pkg::PriceW-1:0]   s_open_price,
    input  wire logic [obr_pkg::PriceW-1:0]   s_high_price,
    input  wire logic [obr_pkg::PriceW-1:0]   s_low_price,
    input  wire logic [obr_pkg::PriceW-1:0]   s_close_price,
    input  wire logic                         s_end_of_series,

    // resampled bars
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [obr_pkg::TimeW-1:0]         m_bar_start,
    output logic [obr_pkg::PriceW-1:0]        m_bar_open,
    output logic [obr_pkg::PriceW-1:0]        m_bar_high,
    output logic [obr_pkg::PriceW-1:0]        m_bar_low,
    output logic [obr_pkg::PriceW-1:0]        m_bar_close,
    output logic                              m_last_result
);
    import obr_pkg::*;

    // period register; writing it only while the block is idle is up to the user
    logic [PeriodW-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PeriodReset;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    // front to queue
    logic  push_valid, push_ready;
    item_t push_item;

    // queue to back
    logic  q_valid, q_pop;
    item_t q_item;

    result_t out_data;

    // front: accept transaction, divide time by period
    obr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .period     (period_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_time    (s_tick_time),
        .in_open    (s_open_price),
        .in_high    (s_high_price),
        .in_low     (s_low_price),
        .in_close   (s_close_price),
        .in_eos     (s_end_of_series),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decouples the divider from output backpressure
    obr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    // back: merge into the open bar, emit on interval change or series end
    obr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // result fields straight from the output register
    assign m_bar_start   = out_data.start;
    assign m_bar_open    = out_data.open;
    assign m_bar_high    = out_data.high;
    assign m_bar_low     = out_data.low;
    assign m_bar_close   = out_data.close;
    assign m_last_result = out_data.last;

endmodule

`default_nettype wire
